@@ hdl/sdmn_pkg.sv @@
// Shared types and constants for the second-derivative min/max normalizer.
// Used by the front, queue, back and top-level modules; no dependencies.
package sdmn_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ENTRY_W  = SAMPLE_W + 7;       // exact stencil sum
  localparam int RANGE_W  = ENTRY_W + 1;        // unsigned max-min and d-min
  localparam int QUO_W    = 18;                 // quotient bits, holds up to 65536
  localparam int NORM_W   = 16;
  localparam int NUM_W    = RANGE_W + QUO_W;    // offset*2^17 + range
  localparam int DEN_W    = RANGE_W + 1;        // 2*range
  localparam int REM_W    = DEN_W + 1;
  localparam int STEP_W   = $clog2(QUO_W);
  localparam int QDEPTH   = 2;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic [NORM_W-1:0] norm_value;
    logic              end_of_run;
    logic              flat;
  } out_item_t;

  // One fetch, resolved by the front and waiting for the divider.
  typedef struct packed {
    logic [RANGE_W-1:0] offset;
    logic [RANGE_W-1:0] span;
    logic               eor;
    logic               flat;
  } q_entry_t;

endpackage

@@ hdl/sdmn_front.sv @@
// Front part: takes load and fetch transactions, runs the five-tap stencil,
// keeps the entry memory and min/max marks, and queues resolved fetches. Uses sdmn_pkg.
module sdmn_front #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  sdmn_pkg::in_item_t       in_item_i,
  input  logic [sdmn_pkg::QCNT_W-1:0] q_count_i,
  output logic                     push_o,
  output sdmn_pkg::q_entry_t       entry_o
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int EW    = sdmn_pkg::ENTRY_W;
  localparam int SW    = sdmn_pkg::SAMPLE_W;
  localparam int RW    = sdmn_pkg::RANGE_W;

  logic signed [SW-1:0] win_q [4];
  logic [CNT_W-1:0]     cnt_q, rd_idx_q;
  logic                 ready_q;
  logic signed [EW-1:0] low_q, high_q;

  logic [EW-1:0]        mem_q [MAX_SAMPLES];
  logic [EW-1:0]        rd_data_q;

  logic                 pend_q, pend_zero_q, pend_eor_q;
  logic signed [EW-1:0] pend_low_q;
  logic [RW-1:0]        pend_span_q;

  logic [sdmn_pkg::QCNT_W:0] occ;
  logic                 accept, load_acc, fetch_acc, fetch_ok;
  logic [CNT_W-1:0]     base_cnt, new_cnt, wr_diff;
  logic signed [EW-1:0] base_lo, base_hi, lo_next, hi_next;
  logic signed [EW-1:0] w0, w1, w2, w3, sx, d;
  logic                 has_d, close_run, rd_zero, rd_eor;
  logic [CNT_W:0]       rd_plus2;
  logic [EW-1:0]        sel;

  // Reserve a queue slot for a fetch that is still reading memory.
  assign occ        = (sdmn_pkg::QCNT_W+1)'(q_count_i) + (sdmn_pkg::QCNT_W+1)'(pend_q);
  assign in_stall_o = occ >= (sdmn_pkg::QCNT_W+1)'(sdmn_pkg::QDEPTH);
  assign accept     = in_valid_i && !in_stall_o;
  assign load_acc   = accept && (in_item_i.kind == sdmn_pkg::KIND_LOAD);
  assign fetch_acc  = accept && (in_item_i.kind == sdmn_pkg::KIND_FETCH);

  // A load after a closed run starts a new run.
  assign base_cnt = ready_q ? '0 : cnt_q;
  assign base_lo  = ready_q ? '0 : low_q;
  assign base_hi  = ready_q ? '0 : high_q;
  assign has_d    = base_cnt >= CNT_W'(4);
  assign wr_diff  = base_cnt - CNT_W'(2);
  assign new_cnt  = base_cnt + CNT_W'(1);
  assign close_run = in_item_i.last || (new_cnt == CNT_W'(MAX_SAMPLES));

  always_comb begin
    w0 = {{(EW-SW){win_q[0][SW-1]}}, win_q[0]};
    w1 = {{(EW-SW){win_q[1][SW-1]}}, win_q[1]};
    w2 = {{(EW-SW){win_q[2][SW-1]}}, win_q[2]};
    w3 = {{(EW-SW){win_q[3][SW-1]}}, win_q[3]};
    sx = {{(EW-SW){in_item_i.sample[SW-1]}}, in_item_i.sample};
    d  = (w1 <<< 4) + (w3 <<< 4) - (w2 <<< 5) + (w2 <<< 1) - w0 - sx;
    lo_next = (has_d && (d < base_lo)) ? d : base_lo;
    hi_next = (has_d && (d > base_hi)) ? d : base_hi;
  end

  // Positions 0, 1 and the last two read as zero; the rest were written this run.
  assign fetch_ok = ready_q && (rd_idx_q < cnt_q);
  assign rd_plus2 = {1'b0, rd_idx_q} + (CNT_W+1)'(2);
  assign rd_zero  = (rd_idx_q < CNT_W'(2)) || (rd_plus2 >= {1'b0, cnt_q});
  assign rd_eor   = (rd_idx_q + CNT_W'(1)) == cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) win_q[i] <= '0;
      cnt_q    <= '0;
      rd_idx_q <= '0;
      ready_q  <= 1'b0;
      low_q    <= '0;
      high_q   <= '0;
      pend_q   <= 1'b0;
    end else begin
      pend_q <= fetch_acc && fetch_ok;
      if (load_acc) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= win_q[3];
        win_q[3] <= in_item_i.sample;
        cnt_q    <= new_cnt;
        rd_idx_q <= '0;
        ready_q  <= close_run;
        low_q    <= lo_next;
        high_q   <= hi_next;
      end else if (fetch_acc && fetch_ok) begin
        rd_idx_q <= rd_idx_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_acc && has_d) begin
      mem_q[wr_diff[IDX_W-1:0]] <= d;
    end
    if (fetch_acc && fetch_ok) begin
      rd_data_q   <= mem_q[rd_idx_q[IDX_W-1:0]];
      pend_zero_q <= rd_zero;
      pend_eor_q  <= rd_eor;
      pend_low_q  <= low_q;
      pend_span_q <= {high_q[EW-1], high_q} - {low_q[EW-1], low_q};
    end
  end

  assign sel            = pend_zero_q ? '0 : rd_data_q;
  assign push_o         = pend_q;
  assign entry_o.offset = {sel[EW-1], sel} - {pend_low_q[EW-1], pend_low_q};
  assign entry_o.span   = pend_span_q;
  assign entry_o.eor    = pend_eor_q;
  assign entry_o.flat   = (pend_span_q == '0);

endmodule

@@ hdl/sdmn_queue.sv @@
// Short FIFO of resolved fetches between the front and the divider back end.
// Uses sdmn_pkg for the entry type and depth.
module sdmn_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  sdmn_pkg::q_entry_t          entry_i,
  input  logic                        pop_i,
  output sdmn_pkg::q_entry_t          head_o,
  output logic                        empty_o,
  output logic [sdmn_pkg::QCNT_W-1:0] count_o
);

  localparam int PTR_W = $clog2(sdmn_pkg::QDEPTH);

  sdmn_pkg::q_entry_t              slot_q [sdmn_pkg::QDEPTH];
  logic [PTR_W-1:0]                wr_ptr_q, rd_ptr_q;
  logic [sdmn_pkg::QCNT_W-1:0]     count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + sdmn_pkg::QCNT_W'(1);
        2'b01:   count_q <= count_q - sdmn_pkg::QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= entry_i;
  end

  assign head_o  = slot_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

@@ hdl/sdmn_back.sv @@
// Back part: pops resolved fetches, divides (d-min)*2^16 by (max-min) with
// rounding one quotient bit per cycle, and holds the result. Uses sdmn_pkg.
module sdmn_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  sdmn_pkg::q_entry_t   q_head_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sdmn_pkg::out_item_t  out_item_o
);

  localparam int QW = sdmn_pkg::QUO_W;
  localparam int NW = sdmn_pkg::NUM_W;
  localparam int DW = sdmn_pkg::DEN_W;
  localparam int MW = sdmn_pkg::REM_W;
  localparam int SW = sdmn_pkg::STEP_W;
  localparam int OW = sdmn_pkg::NORM_W;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} state_e;

  state_e               state_q;
  logic [SW-1:0]        step_q;
  logic [MW-1:0]        rem_q;
  logic [QW-1:0]        bits_q, quo_q;
  logic [DW-1:0]        den_q;
  logic                 eor_q;
  sdmn_pkg::out_item_t  out_q;

  logic [NW-1:0]        num;
  logic [MW-1:0]        trial;
  logic                 ge;
  logic [QW-1:0]        quo_next;

  // Numerator offset*2^17 + range over 2*range gives round-half-up of offset*2^16/range.
  assign num      = {1'b0, q_head_i.offset, (QW-1)'(0)} + NW'(q_head_i.span);
  assign trial    = {rem_q[MW-2:0], bits_q[QW-1]};
  assign ge       = trial >= MW'(den_q);
  assign quo_next = {quo_q[QW-2:0], ge};

  assign q_pop_o     = (state_q == ST_IDLE) && !q_empty_i;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      rem_q   <= '0;
      bits_q  <= '0;
      quo_q   <= '0;
      den_q   <= '0;
      eor_q   <= 1'b0;
      out_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            eor_q <= q_head_i.eor;
            if (q_head_i.flat) begin
              out_q.norm_value <= '0;
              out_q.end_of_run <= q_head_i.eor;
              out_q.flat       <= 1'b1;
              state_q          <= ST_OUT;
            end else begin
              rem_q   <= MW'(num[NW-1:QW]);
              bits_q  <= num[QW-1:0];
              den_q   <= {q_head_i.span, 1'b0};
              quo_q   <= '0;
              step_q  <= '0;
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem_q  <= ge ? (trial - MW'(den_q)) : trial;
          bits_q <= {bits_q[QW-2:0], 1'b0};
          quo_q  <= quo_next;
          step_q <= step_q + SW'(1);
          if (step_q == SW'(QW - 1)) begin
            // Saturate: an entry equal to max lands on 65536.
            out_q.norm_value <= (quo_next[QW-1:OW] != '0) ? '1 : quo_next[OW-1:0];
            out_q.end_of_run <= eor_q;
            out_q.flat       <= 1'b0;
            state_q          <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/second_derivative_minmax_normalize.sv @@
// Top level of the five-point second-derivative min/max normalizer.
// Instantiates sdmn_front, sdmn_queue and sdmn_back; uses sdmn_pkg.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): a transaction with
// kind load adds one sample to the current run; last closes the run, and so
// does the sample that fills MAX_SAMPLES positions. Loads are taken one per
// cycle while in_stall_o is low and never give a result. A load after a closed run starts a new run.
// A transaction with kind fetch returns the next entry of a closed run,
// normalized to (d-min)/(max-min) as unsigned Q0.16, or zero with flat set
// when max equals min. A fetch before the run closes or past its end gives
// no result.
// Output channel (out_valid_o / out_stall_i / out_item_o): one result per
// productive fetch, in order. A stalled result holds in the back end while
// the front keeps taking transactions until two more fetches wait in the queue.
// Each fetch is read from the entry memory into a register, pushed into the
// queue, popped by the back end and divided by the 18-step restoring divider
// (skipped when flat). The back end takes the next fetch only after its result has left.
// Reset clears the sample window, counters, min/max marks and the queue;
// the entry memory needs no clearing.
module second_derivative_minmax_normalize #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sdmn_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sdmn_pkg::out_item_t out_item_o
);

  logic                        push, pop, q_empty;
  sdmn_pkg::q_entry_t          push_entry, head_entry;
  logic [sdmn_pkg::QCNT_W-1:0] q_count;

  sdmn_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_count_i  (q_count),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  sdmn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  sdmn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (head_entry),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  a_flat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.flat) |-> (out_item_o.norm_value == '0))
    else $error("flat result with nonzero value");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (q_count < sdmn_pkg::QCNT_W'(sdmn_pkg::QDEPTH)))
    else $error("fetch pushed into a full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= sdmn_pkg::QCNT_W'(sdmn_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (q_count == $past(q_count) - sdmn_pkg::QCNT_W'(1)))
    else $error("queue count did not drop on pop");

endmodule

@@ bench/second_derivative_minmax_normalize_tb.sv @@
// Self-checking bench for second_derivative_minmax_normalize: directed and random
// waveform runs with random idling on both channels, checked against a local predictor.
// Depends on sdmn_pkg and the second_derivative_minmax_normalize RTL.
module second_derivative_minmax_normalize_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SAMPLES      = 1024;
  localparam int OVERFLOW_FETCHES = 256;
  localparam int RANDOM_ITEMS     = 440;
  localparam int STALL_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 40;

  typedef enum int {
    SHAPE_NOISE,
    SHAPE_SMALL,
    SHAPE_FLAT,
    SHAPE_RAMP,
    SHAPE_RAILS
  } wave_shape_e;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  sdmn_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sdmn_pkg::out_item_t out_item;

  bit                  quiet_sender;
  bit                  quiet_receiver;
  int                  errors;
  int                  idle_cycles = 0;
  sdmn_pkg::out_item_t expected_norm[$];
  sdmn_pkg::out_item_t want;

  // Predictor state
  logic signed [sdmn_pkg::SAMPLE_W-1:0] tap_win [4];
  logic signed [sdmn_pkg::ENTRY_W-1:0]  entry_mem [MAX_SAMPLES];
  logic signed [sdmn_pkg::ENTRY_W-1:0]  min_mark;
  logic signed [sdmn_pkg::ENTRY_W-1:0]  max_mark;
  int unsigned                          run_len;
  int unsigned                          fetch_idx;
  bit                                   run_closed;

  always #5 clk_i = ~clk_i;

  second_derivative_minmax_normalize #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    errors++;
  endtask

  // Update the predictor with one accepted transaction; queue the result it causes.
  task automatic predict_norm(input sdmn_pkg::in_item_t it);
    int unsigned                         slot;
    int                                  acc;
    logic signed [sdmn_pkg::ENTRY_W-1:0] d;
    longint unsigned                     span;
    longint unsigned                     offset;
    longint unsigned                     q;
    sdmn_pkg::out_item_t                 res;
    if (it.kind == sdmn_pkg::KIND_LOAD) begin
      if (run_closed) begin
        run_len    = 0;
        fetch_idx  = 0;
        min_mark   = '0;
        max_mark   = '0;
        run_closed = 1'b0;
      end
      slot = (run_len >= MAX_SAMPLES) ? MAX_SAMPLES - 1 : run_len;
      entry_mem[slot] = '0;
      if (slot >= 4) begin
        acc = -int'(tap_win[0]) + 16 * int'(tap_win[1]) - 30 * int'(tap_win[2])
              + 16 * int'(tap_win[3]) - int'(it.sample);
        d = acc[sdmn_pkg::ENTRY_W-1:0];
        entry_mem[slot-2] = d;
        if (d < min_mark) min_mark = d;
        if (d > max_mark) max_mark = d;
      end
      tap_win[0] = tap_win[1];
      tap_win[1] = tap_win[2];
      tap_win[2] = tap_win[3];
      tap_win[3] = it.sample;
      run_len = slot + 1;
      if (it.last || run_len >= MAX_SAMPLES) begin
        run_closed = 1'b1;
        fetch_idx  = 0;
      end
    end else if (run_closed && fetch_idx < run_len) begin
      d    = entry_mem[fetch_idx];
      span = longint'(max_mark) - longint'(min_mark);
      if (span == 0) begin
        res.norm_value = '0;
        res.flat       = 1'b1;
      end else begin
        offset = longint'(d) - longint'(min_mark);
        q = (offset * 131072 + span) / (2 * span);
        if (q > 65535) q = 65535;
        res.norm_value = q[sdmn_pkg::NORM_W-1:0];
        res.flat       = 1'b0;
      end
      res.end_of_run = (fetch_idx + 1 == run_len);
      fetch_idx++;
      expected_norm.push_back(res);
    end
  endtask

  task automatic send_item(input sdmn_pkg::in_item_t it);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall);
    predict_norm(it);
  endtask

  task automatic send_load(input logic [sdmn_pkg::SAMPLE_W-1:0] s, input bit is_last);
    sdmn_pkg::in_item_t it;
    it.kind   = sdmn_pkg::KIND_LOAD;
    it.sample = s;
    it.last   = is_last;
    send_item(it);
  endtask

  // Sample and last carry random bits; the block must ignore them on a fetch.
  task automatic send_fetch();
    sdmn_pkg::in_item_t it;
    it.kind   = sdmn_pkg::KIND_FETCH;
    it.sample = sdmn_pkg::SAMPLE_W'($urandom);
    it.last   = 1'($urandom_range(1));
    send_item(it);
  endtask

  task automatic hold_input();
    in_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_results();
    hold_input();
    while (expected_norm.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [sdmn_pkg::SAMPLE_W-1:0] pick_sample(wave_shape_e shape,
                                                                int base, int step,
                                                                int idx);
    case (shape)
      SHAPE_NOISE: return sdmn_pkg::SAMPLE_W'($urandom);
      SHAPE_SMALL: return sdmn_pkg::SAMPLE_W'($urandom_range(0, 63))
                          - sdmn_pkg::SAMPLE_W'(32);
      SHAPE_FLAT:  return base[sdmn_pkg::SAMPLE_W-1:0];
      SHAPE_RAMP:  return sdmn_pkg::SAMPLE_W'(base + step * idx);
      default:     return $urandom_range(1) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  // Fetch before any run, fetch into an open run, then a three-sample run.
  task automatic test_early_fetch();
    send_fetch();
    send_load(16'h1234, 1'b0);
    send_load(16'hfedc, 1'b0);
    send_fetch();
    send_load(16'h0001, 1'b1);
    repeat (4) send_fetch();
  endtask

  // Full-scale alternating samples, sent after all pending results have drained.
  task automatic test_extremes();
    wait_results();
    send_load(16'h7fff, 1'b0);
    send_load(16'h8000, 1'b0);
    send_load(16'h7fff, 1'b0);
    send_load(16'h8000, 1'b0);
    send_load(16'h7fff, 1'b0);
    send_load(16'h8000, 1'b1);
    repeat (7) send_fetch();
  endtask

  // A run with no last flag closes itself when the store fills; fetch its head.
  task automatic test_overflow();
    wave_shape_e shape;
    int          base;
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      if (i % 128 == 0) begin
        shape = wave_shape_e'($urandom_range(4));
        base  = $urandom;
      end
      send_load(pick_sample(shape, base, 37, i), 1'b0);
    end
    repeat (OVERFLOW_FETCHES) send_fetch();
  endtask

  task automatic test_random_runs();
    int          sent;
    int          len;
    int          base;
    int          step;
    int          nf;
    wave_shape_e shape;
    bit          close;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet_sender   = ($urandom_range(3) == 0);
      quiet_receiver = ($urandom_range(3) == 0);
      shape = wave_shape_e'($urandom_range(4));
      len   = ($urandom_range(7) == 0) ? $urandom_range(1, 5) : $urandom_range(5, 40);
      base  = $urandom;
      step  = int'($urandom_range(2047)) - 1024;
      for (int i = 0; i < len; i++) begin
        // occasional stray fetch in the middle of a load sequence
        if ($urandom_range(15) == 0) begin
          send_fetch();
          sent++;
        end
        close = (i == len - 1) && ($urandom_range(9) != 0);
        send_load(pick_sample(shape, base, step, i), close);
        sent++;
      end
      if ($urandom_range(5) == 0) wait_results();
      nf = ($urandom_range(7) == 0) ? $urandom_range(0, run_len)
                                    : run_len + $urandom_range(0, 2);
      repeat (nf) begin
        send_fetch();
        sent++;
      end
    end
    quiet_sender   = 1'b0;
    quiet_receiver = 1'b0;
  endtask

  initial begin : result_sink
    int gap;
    wait (rst_ni);
    forever begin
      gap = quiet_receiver ? 0 : $urandom_range(3);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_norm.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = expected_norm.pop_front();
        if (out_item.norm_value !== want.norm_value)
          report_mismatch($sformatf("norm_value got %0d want %0d",
                                    out_item.norm_value, want.norm_value));
        if (out_item.end_of_run !== want.end_of_run)
          report_mismatch($sformatf("end_of_run got %b want %b",
                                    out_item.end_of_run, want.end_of_run));
        if (out_item.flat !== want.flat)
          report_mismatch($sformatf("flat got %b want %b", out_item.flat, want.flat));
      end
    end
  end

  // Count cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("[second_derivative_minmax_normalize] ERROR");
      $finish;
    end
  end

  initial begin
    errors = 0;
    for (int i = 0; i < 4; i++) tap_win[i] = '0;
    min_mark   = '0;
    max_mark   = '0;
    run_len    = 0;
    fetch_idx  = 0;
    run_closed = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_early_fetch();
    test_extremes();
    test_overflow();
    test_random_runs();

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_norm.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_norm.size()));
    if (errors == 0) begin
      $display("[second_derivative_minmax_normalize] OK");
    end else begin
      $display("[second_derivative_minmax_normalize] ERROR");
    end
    $finish;
  end

endmodule
